[rtl/core/bqf_pkg.sv]
// ----------------------------------------------------------------------------
// Biquad PCM output package
// Shared types and constants for the direct-form-I biquad with PCM output.
// ----------------------------------------------------------------------------
package bqf_pkg;

  // Fixed datapath widths
  localparam int unsigned MulW = 32;  // multiplier operand width
  localparam int unsigned AccW = 64;  // accumulator and product width
  localparam int unsigned YW   = 32;  // stored filter output width
  localparam int unsigned PcmW = 16;  // PCM sample width
  localparam int unsigned IdxW = 3;   // configuration register index width

  localparam logic signed [MulW-1:0] ScaleK  = 32'sd32767;
  localparam logic signed [PcmW-1:0] PcmMax  = 16'sd32767;
  localparam logic signed [PcmW-1:0] PcmMin  = -16'sd32768;
  localparam logic signed [AccW-1:0] YMax    = 64'sd2147483647;
  localparam logic signed [AccW-1:0] YMin    = -64'sd2147483648;

  // Configuration register indexes
  typedef enum logic [IdxW-1:0] {
    REG_A0 = 3'd0,
    REG_A1 = 3'd1,
    REG_A2 = 3'd2,
    REG_B1 = 3'd3,
    REG_B2 = 3'd4
  } bqf_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_NORM,
    ST_SCALE,
    ST_FIN
  } bqf_state_e;

  // Product selected for the shared multiplier
  typedef enum logic [2:0] {
    TERM_A0    = 3'd0,
    TERM_A1    = 3'd1,
    TERM_A2    = 3'd2,
    TERM_B1    = 3'd3,
    TERM_B2    = 3'd4,
    TERM_SCALE = 3'd5
  } bqf_term_e;

  // Sequencer to datapath controls
  typedef struct packed {
    logic      in_ready;
    logic      acc_clr;
    logic      mul_en;
    bqf_term_e term;
    logic      acc_en;
    logic      norm_en;
    logic      fin_en;
  } bqf_ctrl_t;

endpackage

[rtl/core/bqf_in_if.sv]
// ----------------------------------------------------------------------------
// Biquad input channel
// Valid/ready channel carrying one signed audio sample per beat.
// ----------------------------------------------------------------------------
interface bqf_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

[rtl/core/bqf_out_if.sv]
// ----------------------------------------------------------------------------
// Biquad PCM output channel
// Valid/ready channel carrying one 16-bit PCM sample and a clip flag per beat.
// ----------------------------------------------------------------------------
interface bqf_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       pcm_sample;
  logic                     clipped;

  modport source (output valid, output pcm_sample, output clipped, input ready);
  modport sink   (input valid, input pcm_sample, input clipped, output ready);
endinterface

[rtl/core/bqf_ctrl.sv]
// ----------------------------------------------------------------------------
// Biquad sequencer
// Steps the shared multiply-accumulate unit through the five filter terms,
// the output normalization, the PCM scaling and the output load.
// ----------------------------------------------------------------------------
module bqf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_free_i,
  output bqf_pkg::bqf_ctrl_t ctrl_o
);

  localparam logic [2:0] LastStep = 3'd5;

  bqf_pkg::bqf_state_e state_q, state_d;
  logic [2:0]          cnt_q, cnt_d;

  // Next state and step counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      bqf_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = bqf_pkg::ST_MAC;
        end
      end
      bqf_pkg::ST_MAC: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == LastStep) begin
          state_d = bqf_pkg::ST_NORM;
        end
      end
      bqf_pkg::ST_NORM:  state_d = bqf_pkg::ST_SCALE;
      bqf_pkg::ST_SCALE: state_d = bqf_pkg::ST_FIN;
      bqf_pkg::ST_FIN: begin
        if (out_free_i) begin
          state_d = bqf_pkg::ST_IDLE;
        end
      end
      default: state_d = bqf_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.term     = bqf_pkg::TERM_A0;
    case (state_q)
      bqf_pkg::ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.acc_clr  = in_valid_i;
      end
      bqf_pkg::ST_MAC: begin
        // issue term cnt, accumulate the registered product of the previous term
        ctrl_o.mul_en = (cnt_q != LastStep);
        ctrl_o.term   = bqf_pkg::bqf_term_e'(cnt_q);
        ctrl_o.acc_en = (cnt_q != 3'd0);
      end
      bqf_pkg::ST_NORM: ctrl_o.norm_en = 1'b1;
      bqf_pkg::ST_SCALE: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.term   = bqf_pkg::TERM_SCALE;
      end
      bqf_pkg::ST_FIN: ctrl_o.fin_en = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bqf_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/core/bqf_mac.sv]
// ----------------------------------------------------------------------------
// Biquad multiply-accumulate unit
// One 32x32 signed multiplier with a product register, feeding a 64-bit
// accumulator that saturates at every addition.
// ----------------------------------------------------------------------------
module bqf_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bqf_pkg::bqf_ctrl_t                   ctrl_i,
  input  logic signed [bqf_pkg::MulW-1:0]      op_a_i,
  input  logic signed [bqf_pkg::MulW-1:0]      op_b_i,
  output logic signed [bqf_pkg::AccW-1:0]      prod_o,
  output logic signed [bqf_pkg::AccW-1:0]      acc_o
);

  logic signed [bqf_pkg::AccW-1:0] prod_q;
  logic                            sub_q;
  logic signed [bqf_pkg::AccW-1:0] acc_q, acc_d;
  logic signed [bqf_pkg::AccW:0]   addend;
  logic signed [bqf_pkg::AccW:0]   sum;

  // Feedback terms are subtracted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else if (ctrl_i.mul_en) begin
      sub_q <= (ctrl_i.term == bqf_pkg::TERM_B1) || (ctrl_i.term == bqf_pkg::TERM_B2);
    end
  end

  // Register the product
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= op_a_i * op_b_i;
    end
  end

  // Saturating add or subtract into the accumulator
  always_comb begin
    addend = sub_q ? -((bqf_pkg::AccW+1)'(prod_q)) : (bqf_pkg::AccW+1)'(prod_q);
    sum    = (bqf_pkg::AccW+1)'(acc_q) + addend;
    if (sum[bqf_pkg::AccW] != sum[bqf_pkg::AccW-1]) begin
      acc_d = {sum[bqf_pkg::AccW], {(bqf_pkg::AccW-1){~sum[bqf_pkg::AccW]}}};
    end else begin
      acc_d = sum[bqf_pkg::AccW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

[rtl/core/biquad_filter_pcm_output_core.sv]
// ----------------------------------------------------------------------------
// Biquad filter with PCM output
// Direct-form-I biquad on signed fixed-point samples; the filtered value is
// scaled by 32767, truncated toward zero and clamped to a 16-bit PCM sample.
//
//  channel   dir  payload                         beat when
//  in_i      in   in_sample (SAMPLE_WIDTH, s)     valid & ready
//  pcm_o     out  pcm_sample (16, s), clipped     valid & ready
//  cfg_*     in   cfg_idx_i, cfg_data_i           cfg_we_i
//
// Per sample, with the output free, the steps are: the idle state that takes
// the beat, five multiplier passes for the filter terms, one step to add the
// last product, normalize, the PCM scale pass and the output load.
// The single multiplier sets the rate.
// A finished sample waits in the output register; the sequencer stalls in
// its last step only while that register is still full.
// Reset clears the filter history and loads the coefficient reset values.
// ----------------------------------------------------------------------------
module biquad_filter_pcm_output_core #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned FRAC_BITS    = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  bqf_in_if.sink                              in_i,
  bqf_out_if.source                           pcm_o,
  input  logic                                cfg_we_i,
  input  logic [bqf_pkg::IdxW-1:0]            cfg_idx_i,
  input  logic [SAMPLE_WIDTH-1:0]             cfg_data_i
);

  localparam int unsigned MW = bqf_pkg::MulW;
  localparam int unsigned AW = bqf_pkg::AccW;

  localparam logic signed [MW-1:0] A0Reset = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [AW-1:0] PHi     = 64'sd32767 <<< FRAC_BITS;
  localparam logic signed [AW-1:0] PLo     = -(64'sd32768 <<< FRAC_BITS);
  localparam logic signed [AW-1:0] RndAdd  = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  bqf_pkg::bqf_ctrl_t ctrl;
  logic               out_free;

  // Coefficients are held sign-extended so the a0 reset of 1.0 is exact
  logic signed [MW-1:0] a0_q, a1_q, a2_q, b1_q, b2_q;
  logic signed [MW-1:0] x_q, x1_q, x2_q, y1_q, y2_q;
  logic signed [MW-1:0] cfg_ext;
  logic signed [MW-1:0] op_a, op_b;
  logic signed [AW-1:0] prod, acc;
  logic signed [AW-1:0] acc_sh;
  logic signed [MW-1:0] y_new;
  logic signed [AW-1:0] p_adj;
  logic signed [AW-1:0] p_shr;
  logic signed [15:0]   pcm_d;
  logic                 clip_d;
  logic                 out_valid_q;
  logic signed [15:0]   pcm_q;
  logic                 clip_q;

  // Sequencer
  bqf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  assign in_i.ready = ctrl.in_ready;

  // Configuration writes; unknown indexes are dropped
  assign cfg_ext = MW'(signed'(cfg_data_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a0_q <= A0Reset;
      a1_q <= '0;
      a2_q <= '0;
      b1_q <= '0;
      b2_q <= '0;
    end else if (cfg_we_i) begin
      case (bqf_pkg::bqf_reg_e'(cfg_idx_i))
        bqf_pkg::REG_A0: a0_q <= cfg_ext;
        bqf_pkg::REG_A1: a1_q <= cfg_ext;
        bqf_pkg::REG_A2: a2_q <= cfg_ext;
        bqf_pkg::REG_B1: b1_q <= cfg_ext;
        bqf_pkg::REG_B2: b2_q <= cfg_ext;
        default: ;
      endcase
    end
  end

  // Capture the input sample
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      x_q <= MW'(signed'(in_i.in_sample));
    end
  end

  // Select multiplier operands
  always_comb begin
    case (ctrl.term)
      bqf_pkg::TERM_A0:    begin op_a = a0_q; op_b = x_q;            end
      bqf_pkg::TERM_A1:    begin op_a = a1_q; op_b = x1_q;           end
      bqf_pkg::TERM_A2:    begin op_a = a2_q; op_b = x2_q;           end
      bqf_pkg::TERM_B1:    begin op_a = b1_q; op_b = y1_q;           end
      bqf_pkg::TERM_B2:    begin op_a = b2_q; op_b = y2_q;           end
      bqf_pkg::TERM_SCALE: begin op_a = y1_q; op_b = bqf_pkg::ScaleK; end
      default:             begin op_a = '0;   op_b = '0;             end
    endcase
  end

  bqf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  // Normalize: floor shift, saturate to 32 bits
  always_comb begin
    acc_sh = acc >>> FRAC_BITS;
    if (acc_sh > bqf_pkg::YMax) begin
      y_new = MW'(bqf_pkg::YMax);
    end else if (acc_sh < bqf_pkg::YMin) begin
      y_new = MW'(bqf_pkg::YMin);
    end else begin
      y_new = acc_sh[MW-1:0];
    end
  end

  // Advance the filter history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (ctrl.norm_en) begin
      x2_q <= x1_q;
      x1_q <= x_q;
      y2_q <= y1_q;
      y1_q <= y_new;
    end
  end

  // Clamp and truncate the scaled value toward zero
  always_comb begin
    p_adj  = prod[AW-1] ? (prod + RndAdd) : prod;
    p_shr  = p_adj >>> FRAC_BITS;
    clip_d = 1'b0;
    if (prod > PHi) begin
      pcm_d  = bqf_pkg::PcmMax;
      clip_d = 1'b1;
    end else if (prod < PLo) begin
      pcm_d  = bqf_pkg::PcmMin;
      clip_d = 1'b1;
    end else begin
      pcm_d = p_shr[15:0];
    end
  end

  // Output register
  assign out_free = !out_valid_q || pcm_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.fin_en) begin
      out_valid_q <= 1'b1;
    end else if (pcm_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fin_en) begin
      pcm_q  <= pcm_d;
      clip_q <= clip_d;
    end
  end

  assign pcm_o.valid      = out_valid_q;
  assign pcm_o.pcm_sample = pcm_q;
  assign pcm_o.clipped    = clip_q;

`ifndef SYNTH
  // No second beat can enter right after one was taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while a sample is in work");

  // History advances exactly once the five terms are summed
  a_norm_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> ##7 ctrl.norm_en)
    else $error("normalize step out of sequence");

  // Output only loads into a free slot
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.fin_en |-> (!out_valid_q || pcm_o.ready))
    else $error("pending output beat overwritten");

  // Clip flag only with a clamped sample
  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && clip_q) |-> (pcm_q == bqf_pkg::PcmMax || pcm_q == bqf_pkg::PcmMin))
    else $error("clip flag without clamped value");
`endif

endmodule

[bench/tb_biquad_filter_pcm_output_core.sv]
// ----------------------------------------------------------------------------
// Biquad PCM output core testbench
// Drives mono audio samples through the direct-form-I biquad under a series
// of coefficient sets and predicts every PCM beat in fixed point: the filter
// sum, the 32-bit output saturation, the scale to 16 bits and the clip flag.
// Both channels idle and stall at random; coefficients change only when the
// filter has drained.
// ----------------------------------------------------------------------------
module tb_biquad_filter_pcm_output_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SampleW      = 24;
  localparam int unsigned FracBits     = 20;
  localparam int unsigned IdxW         = bqf_pkg::IdxW;
  localparam int unsigned PcmW         = bqf_pkg::PcmW;
  localparam int unsigned ClkPeriod    = 8;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned NumCoefs     = int'(bqf_pkg::REG_B2) + 1;
  localparam int unsigned NumPhases    = 9;
  localparam int unsigned PhaseItems   = 180;
  localparam int unsigned StallPhase   = 3;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned CycleLimit   = 400000;
  localparam int          Unity        = 1 << FracBits;
  localparam int          NearSpan     = Unity + (Unity >> 4);

  localparam logic [IdxW-1:0]    IdxSpareFirst = IdxW'(NumCoefs);
  localparam logic [SampleW-1:0] CoefMax       = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic [SampleW-1:0] CoefMin       = {1'b1, {(SampleW-1){1'b0}}};

  typedef struct packed {
    logic signed [PcmW-1:0] pcm;
    logic                   clipped;
  } pcm_beat_t;

  typedef enum int {
    SET_TAME,
    SET_FULL,
    SET_MAX,
    SET_MIN,
    SET_ZERO
  } coef_set_e;

  // Fixed-point model of the filter plus the queue of PCM beats it owes.
  class biquad_pcm_predictor;
    longint    coef[NumCoefs];
    longint    x_1, x_2, y_1, y_2;
    pcm_beat_t pending_pcm[$];
    int unsigned mismatches, checked, clips;

    function new();
      foreach (coef[i]) coef[i] = 0;
      coef[bqf_pkg::REG_A0] = longint'(Unity);
      x_1 = 0;
      x_2 = 0;
      y_1 = 0;
      y_2 = 0;
      mismatches = 0;
      checked = 0;
      clips = 0;
    endfunction

    // Indexes past the last coefficient write nothing.
    function void load_coef(logic [IdxW-1:0] idx, logic [SampleW-1:0] value);
      if (idx <= bqf_pkg::REG_B2) coef[idx] = longint'($signed(value));
    endfunction

    function void predict_sample(logic signed [SampleW-1:0] x);
      longint    acc, y, scaled;
      pcm_beat_t beat;
      // Products and their sum stay well inside 64 bits at these widths.
      acc = coef[bqf_pkg::REG_A0] * longint'(x) + coef[bqf_pkg::REG_A1] * x_1
            + coef[bqf_pkg::REG_A2] * x_2
            - coef[bqf_pkg::REG_B1] * y_1 - coef[bqf_pkg::REG_B2] * y_2;
      y = acc >>> FracBits;
      if (y > bqf_pkg::YMax) y = bqf_pkg::YMax;
      if (y < bqf_pkg::YMin) y = bqf_pkg::YMin;
      x_2 = x_1;
      x_1 = longint'(x);
      y_2 = y_1;
      y_1 = y;
      // Scale to PCM, clamp on the exact product, else truncate toward zero.
      scaled = y * longint'(bqf_pkg::ScaleK);
      if (scaled > (longint'(bqf_pkg::PcmMax) <<< FracBits)) begin
        beat.pcm = bqf_pkg::PcmMax;
        beat.clipped = 1'b1;
      end else if (scaled < (longint'(bqf_pkg::PcmMin) <<< FracBits)) begin
        beat.pcm = bqf_pkg::PcmMin;
        beat.clipped = 1'b1;
      end else begin
        beat.pcm = PcmW'((scaled >= 0) ? (scaled >>> FracBits) : -((-scaled) >>> FracBits));
        beat.clipped = 1'b0;
      end
      pending_pcm.push_back(beat);
    endfunction

    function void check_pcm(logic signed [PcmW-1:0] pcm, logic clipped);
      pcm_beat_t want;
      if (pending_pcm.size() == 0) begin
        $error("unexpected PCM beat: pcm_sample=%0d clipped=%0b", pcm, clipped);
        mismatches++;
      end else begin
        want = pending_pcm.pop_front();
        checked++;
        if (want.clipped) clips++;
        if (pcm !== want.pcm) begin
          $error("pcm_sample: expected %0d, actual %0d", want.pcm, pcm);
          mismatches++;
        end
        if (clipped !== want.clipped) begin
          $error("clipped: expected %0b, actual %0b", want.clipped, clipped);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [IdxW-1:0]     cfg_idx_i;
  logic [SampleW-1:0]  cfg_data_i;

  bqf_in_if #(.SAMPLE_WIDTH(SampleW)) in_if ();
  bqf_out_if                          pcm_if ();

  biquad_filter_pcm_output_core #(
    .SAMPLE_WIDTH(SampleW),
    .FRAC_BITS   (FracBits)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .pcm_o     (pcm_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  biquad_pcm_predictor predictor = new();

  logic [SampleW-1:0] next_coef[NumCoefs];
  bit          send_lazy   = 1'b0;
  bit          recv_lazy   = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned sets_loaded = 0;
  int unsigned cycle_count = 0;

  // Unity-gain corners: zero, lsb rounding, full scale and the clamp edges.
  logic signed [SampleW-1:0] corner_samples[15] = '{
    24'sd0, 24'sd1, -24'sd1, 24'sd31, 24'sd32, -24'sd31, -24'sd32,
    24'sd1048576, 24'sd1048577, -24'sd1048608, -24'sd1048609,
    24'sd8388607, -24'sd8388608, 24'sh555555, 24'shAAAAAA
  };

  coef_set_e phase_plan[NumPhases] = '{
    SET_TAME, SET_FULL, SET_TAME, SET_MAX, SET_TAME,
    SET_MIN, SET_ZERO, SET_FULL, SET_TAME
  };

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("biquad_filter_pcm_output_core regression: fail");
      $finish;
    end
  end

  // Offer one sample; hold valid across back-to-back beats.
  task automatic send_sample(input logic signed [SampleW-1:0] sample);
    int unsigned gap;
    gap = send_lazy ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.in_sample <= sample;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predictor.predict_sample(sample);
  endtask

  // Drop valid and wait for every owed PCM beat.
  task automatic drain_pcm();
    in_if.valid <= 1'b0;
    while (predictor.pending_pcm.size() != 0) @(posedge clk_i);
  endtask

  // Load next_coef once the filter is idle, then poke the unused indexes.
  task automatic apply_coefs();
    bqf_pkg::bqf_reg_e  r;
    logic [SampleW-1:0] junk;
    drain_pcm();
    r = bqf_pkg::REG_A0;
    repeat (NumCoefs) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= r;
      cfg_data_i <= next_coef[r];
      @(posedge clk_i);
      predictor.load_coef(r, next_coef[r]);
      r = r.next();
    end
    for (int i = IdxSpareFirst; i < (1 << IdxW); i++) begin
      junk = SampleW'($urandom);
      cfg_idx_i  <= IdxW'(i);
      cfg_data_i <= junk;
      @(posedge clk_i);
      predictor.load_coef(IdxW'(i), junk);
    end
    cfg_we_i <= 1'b0;
    sets_loaded++;
  endtask

  function automatic void fill_coefs(coef_set_e kind);
    foreach (next_coef[i]) begin
      case (kind)
        SET_FULL: next_coef[i] = SampleW'($urandom);
        SET_MAX:  next_coef[i] = CoefMax;
        SET_MIN:  next_coef[i] = CoefMin;
        SET_ZERO: next_coef[i] = '0;
        default:  next_coef[i] = SampleW'(int'($urandom_range(0, 2 * Unity)) - Unity);
      endcase
    end
    // Keep the second pole coefficient small so tame sets mostly ring, not rail.
    if (kind == SET_TAME) begin
      next_coef[bqf_pkg::REG_B2] = SampleW'(int'($urandom_range(0, Unity)) - Unity / 2);
    end
  endfunction

  // Half the samples within just over PCM full scale, some anywhere, a few zero or at the rails.
  function automatic logic signed [SampleW-1:0] draw_sample();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return SampleW'(int'($urandom_range(0, 2 * NearSpan)) - NearSpan);
    end else if (pick < 88) begin
      return SampleW'($urandom);
    end else if (pick < 92) begin
      return '0;
    end else if (pick < 96) begin
      return CoefMax;
    end else begin
      return CoefMin;
    end
  endfunction

  // PCM sink: random back-pressure plus one long hold.
  initial begin : pcm_sink
    int unsigned gap;
    pcm_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = recv_lazy ? $urandom_range(0, 3) : 0;
      if (hold_cycles != 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end
      if (gap != 0) begin
        pcm_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pcm_if.ready <= 1'b1;
      do @(posedge clk_i); while (pcm_if.valid !== 1'b1);
      predictor.check_pcm(pcm_if.pcm_sample, pcm_if.clipped);
    end
  end

  initial begin : stimulus
    in_if.valid     <= 1'b0;
    in_if.in_sample <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients pass the sample straight through.
    foreach (corner_samples[i]) send_sample(corner_samples[i]);

    // Rail every coefficient with feedback that grows: force output saturation.
    next_coef = '{CoefMax, CoefMax, CoefMax, CoefMin, CoefMin};
    apply_coefs();
    repeat (4) send_sample(CoefMax);
    repeat (4) send_sample(CoefMin);

    // Random phases, one coefficient set each.
    for (int p = 0; p < NumPhases; p++) begin
      fill_coefs(phase_plan[p]);
      apply_coefs();
      send_lazy = (p % 3) != 0;
      recv_lazy = (p % 4) != 1;
      if (p == StallPhase) hold_cycles = LongHold;
      repeat (PhaseItems) send_sample(draw_sample());
    end

    drain_pcm();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Filtered %0d samples under %0d coefficient sets; %0d PCM beats clipped.",
             predictor.checked, sets_loaded + 1, predictor.clips);
    if (predictor.mismatches == 0 && predictor.pending_pcm.size() == 0) begin
      $display("biquad_filter_pcm_output_core regression: pass");
    end else begin
      $display("biquad_filter_pcm_output_core regression: fail");
    end
    $finish;
  end

endmodule
